/* src/led_matrix_scan_driver_core_assert.svh */
// ----------------------------------------------------------------------------
// LED matrix scan driver assertion macros
// Shared assertion forms used by the scan driver core.
// ----------------------------------------------------------------------------
`ifndef LED_MATRIX_SCAN_DRIVER_CORE_ASSERT_SVH
`define LED_MATRIX_SCAN_DRIVER_CORE_ASSERT_SVH

// General form with an explicit clock and reset.
`define LMSD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Form bound to the core clock and reset.
`define LMSD_ASSERT_CORE(label, prop, msg) \
   `LMSD_ASSERT(label, clock, reset, prop, msg)

`endif

/* src/lmsd_pkg.sv */
// ----------------------------------------------------------------------------
// LED matrix scan driver package
// Types and fixed constants shared by the scan driver modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lmsd_pkg;

   localparam int STORE_DEPTH  = 2048;
   localparam int STORE_AW     = 11;
   localparam int PIXEL_W      = 24;
   localparam int PANEL_HEIGHT = 32;
   localparam int HALF_ROWS    = 16;
   localparam int ROW_W        = 4;
   localparam int Y_W          = 7;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QUEUE_AW     = 1;

   localparam logic [7:0] THRESHOLD_RESET = 8'd128;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_TICK  = 1'b1;
   localparam logic EV_SHIFT = 1'b0;
   localparam logic EV_LATCH = 1'b1;

   typedef struct packed {
      logic                tick;
      logic [STORE_AW-1:0] index;
      logic [PIXEL_W-1:0]  pixel;
   } cmd_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

endpackage

`default_nettype wire

/* src/lmsd_queue.sv */
// ----------------------------------------------------------------------------
// LED matrix scan driver command queue
// Small FIFO that decouples the accepting front end from the executing back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lmsd_queue
   import lmsd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_data,
   output logic         push_ready,
   input  wire logic    pop,
   output logic         pop_valid,
   output cmd_type      pop_data
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* src/lmsd_front.sv */
// ----------------------------------------------------------------------------
// LED matrix scan driver front end
// Accepts input beats, unpacks and classifies them, and drops pixel writes
// that fall outside the panel before they reach the command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lmsd_front
   import lmsd_pkg::*;
#(
   parameter int PANEL_WIDTH = 64,
   parameter int PANEL_ROWS  = 1
) (
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   input  wire logic [39:0]     req_tdata,
   input  wire logic            req_tuser,
   input  wire back_status_type status,
   input  wire logic            q_ready,
   output logic                 push,
   output cmd_type              push_data
);

   localparam int TOTAL = PANEL_WIDTH * PANEL_HEIGHT * PANEL_ROWS;

   logic [STORE_AW-1:0] index;
   logic                in_range;

   assign index      = req_tdata[10:0];
   assign in_range   = (32'(index) < TOTAL);
   assign req_tready = q_ready && !status.clearing;

   always_comb begin
      push_data.tick  = (req_tuser == OP_TICK);
      push_data.index = index;
      push_data.pixel = {req_tdata[18:11], req_tdata[26:19], req_tdata[34:27]};
      // Ticks always go through; writes only when they land on the panel.
      push = req_tvalid && req_tready && (push_data.tick || in_range);
   end

endmodule

`default_nettype wire

/* src/lmsd_back.sv */
// ----------------------------------------------------------------------------
// LED matrix scan driver back end
// Holds the write and display stores, clears the write store after reset, runs the
// scan counters, performs the frame-start snapshot copy and drives the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lmsd_back
   import lmsd_pkg::*;
#(
   parameter int PANEL_WIDTH = 64,
   parameter int PANEL_ROWS  = 1
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [7:0]  threshold,
   input  wire logic        q_valid,
   input  wire cmd_type     q_data,
   output logic             q_pop,
   output back_status_type  status,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,
   output logic             rsp_tuser,
   output logic             rsp_tlast
);

   localparam int TOTAL  = PANEL_WIDTH * PANEL_HEIGHT * PANEL_ROWS;
   localparam int FULL_W = $clog2(TOTAL);
   localparam int AW     = (FULL_W > STORE_AW) ? FULL_W : STORE_AW + 1;
   localparam int COL_W  = (PANEL_WIDTH > 1) ? $clog2(PANEL_WIDTH) : 1;
   localparam int PAN_W  = $clog2(PANEL_ROWS + 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_EXEC,
      ST_COPY,
      ST_DRAIN,
      ST_RESP
   } state_type;

   function automatic logic [2:0] colour_bits(input logic [PIXEL_W-1:0] pix,
                                              input logic [7:0] thr);
      colour_bits = {pix[7:0] > thr, pix[15:8] > thr, pix[23:16] > thr};
   endfunction

   logic [PIXEL_W-1:0] ws_mem [STORE_DEPTH];
   logic [PIXEL_W-1:0] ds_mem [STORE_DEPTH];

   state_type           state_ff, state_in;
   logic [STORE_AW-1:0] cnt_ff, cnt_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [PAN_W-1:0]    panel_ff, panel_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic                started_ff, started_in;
   logic                pend_latch_ff, pend_latch_in;
   logic [ROW_W-1:0]    pend_row_ff, pend_row_in;
   logic                pend_last_ff, pend_last_in;
   logic                oob1_ff, oob1_in;
   logic                oob2_ff, oob2_in;
   logic                out_valid_ff, out_valid_in;
   logic                out_kind_ff, out_kind_in;
   logic                out_last_ff, out_last_in;
   logic [15:0]         out_data_ff, out_data_in;
   logic                cp_wen_ff, cp_wen_in;
   logic [STORE_AW-1:0] cp_waddr_ff, cp_waddr_in;

   logic [PIXEL_W-1:0]  ws_q_ff;
   logic [PIXEL_W-1:0]  ds_q1_ff, ds_q2_ff;

   logic                ws_we;
   logic [STORE_AW-1:0] ws_waddr;
   logic [PIXEL_W-1:0]  ws_wdata;
   logic                rd_en;
   logic [Y_W-1:0]      y;
   logic [AW-1:0]       a1, a2;
   logic                latch_due;
   logic                out_free;
   logic [2:0]          upper_rgb, lower_rgb;

   assign y  = Y_W'(row_ff) + Y_W'(panel_ff) * Y_W'(PANEL_HEIGHT);
   assign a1 = AW'(y) * AW'(PANEL_WIDTH) + AW'(col_ff);
   assign a2 = (AW'(y) + AW'(HALF_ROWS)) * AW'(PANEL_WIDTH) + AW'(col_ff);

   assign latch_due = (panel_ff >= PAN_W'(PANEL_ROWS));
   assign out_free  = !out_valid_ff || rsp_tready;
   assign upper_rgb = oob1_ff ? 3'd0 : colour_bits(ds_q1_ff, threshold);
   assign lower_rgb = oob2_ff ? 3'd0 : colour_bits(ds_q2_ff, threshold);

   assign status.clearing = (state_ff == ST_CLEAR);
   assign rsp_tvalid      = out_valid_ff;
   assign rsp_tdata       = out_data_ff;
   assign rsp_tuser       = out_kind_ff;
   assign rsp_tlast       = out_last_ff;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      row_in        = row_ff;
      panel_in      = panel_ff;
      col_in        = col_ff;
      started_in    = started_ff;
      pend_latch_in = pend_latch_ff;
      pend_row_in   = pend_row_ff;
      pend_last_in  = pend_last_ff;
      oob1_in       = oob1_ff;
      oob2_in       = oob2_ff;
      out_valid_in  = out_valid_ff;
      out_kind_in   = out_kind_ff;
      out_last_in   = out_last_ff;
      out_data_in   = out_data_ff;
      cp_wen_in     = 1'b0;
      cp_waddr_in   = cnt_ff;
      ws_we         = 1'b0;
      ws_waddr      = q_data.index;
      ws_wdata      = q_data.pixel;
      rd_en         = 1'b0;
      q_pop         = 1'b0;

      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            ws_we    = 1'b1;
            ws_waddr = cnt_ff;
            ws_wdata = '0;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == '1) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (q_valid) begin
               if (!q_data.tick) begin
                  ws_we = 1'b1;
                  q_pop = 1'b1;
               end else if (!started_ff) begin
                  // First tick of a frame: snapshot the write store first.
                  state_in = ST_COPY;
                  cnt_in   = '0;
               end else begin
                  q_pop       = 1'b1;
                  state_in    = ST_RESP;
                  pend_row_in = row_ff;
                  if (latch_due) begin
                     pend_latch_in = 1'b1;
                     pend_last_in  = (row_ff == ROW_W'(HALF_ROWS - 1));
                     panel_in      = '0;
                     col_in        = '0;
                     row_in        = row_ff + 1'b1;
                     if (row_ff == ROW_W'(HALF_ROWS - 1)) begin
                        started_in = 1'b0;
                     end
                  end else begin
                     rd_en         = 1'b1;
                     pend_latch_in = 1'b0;
                     pend_last_in  = 1'b0;
                     oob1_in       = (a1 >= AW'(STORE_DEPTH));
                     oob2_in       = (a2 >= AW'(STORE_DEPTH));
                     if (col_ff == COL_W'(PANEL_WIDTH - 1)) begin
                        col_in   = '0;
                        panel_in = panel_ff + 1'b1;
                     end else begin
                        col_in = col_ff + 1'b1;
                     end
                  end
               end
            end
         end
         ST_COPY: begin
            cp_wen_in   = 1'b1;
            cp_waddr_in = cnt_ff;
            cnt_in      = cnt_ff + 1'b1;
            if (cnt_ff == '1) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // The last copied entry lands in the display store this cycle.
            started_in = 1'b1;
            state_in   = ST_EXEC;
         end
         ST_RESP: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_kind_in  = pend_latch_ff ? EV_LATCH : EV_SHIFT;
               out_last_in  = pend_latch_ff && pend_last_ff;
               if (pend_latch_ff) begin
                  out_data_in = {6'd0, pend_row_ff, 3'd0, 3'd0};
               end else begin
                  out_data_in = {6'd0, pend_row_ff, lower_rgb, upper_rgb};
               end
               state_in = ST_EXEC;
            end
         end
         default: begin
            state_in = ST_EXEC;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         row_ff       <= '0;
         panel_ff     <= '0;
         col_ff       <= '0;
         started_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         cp_wen_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         row_ff       <= row_in;
         panel_ff     <= panel_in;
         col_ff       <= col_in;
         started_ff   <= started_in;
         out_valid_ff <= out_valid_in;
         cp_wen_ff    <= cp_wen_in;
      end
      pend_latch_ff <= pend_latch_in;
      pend_row_ff   <= pend_row_in;
      pend_last_ff  <= pend_last_in;
      oob1_ff       <= oob1_in;
      oob2_ff       <= oob2_in;
      out_kind_ff   <= out_kind_in;
      out_last_ff   <= out_last_in;
      out_data_ff   <= out_data_in;
      cp_waddr_ff   <= cp_waddr_in;
   end

   always_ff @(posedge clock) begin
      if (ws_we) begin
         ws_mem[ws_waddr] <= ws_wdata;
      end
      ws_q_ff <= ws_mem[cnt_ff];
   end

   always_ff @(posedge clock) begin
      if (cp_wen_ff) begin
         ds_mem[cp_waddr_ff] <= ws_q_ff;
      end
      if (rd_en) begin
         ds_q1_ff <= ds_mem[a1[STORE_AW-1:0]];
         ds_q2_ff <= ds_mem[a2[STORE_AW-1:0]];
      end
   end

endmodule

`default_nettype wire

/* src/led_matrix_scan_driver_core.sv */
// ----------------------------------------------------------------------------
// LED matrix scan driver core
// Scans a two-half LED panel at one bit per color: pixel writes fill a write
// store, ticks produce shift and latch beats from a per-frame display copy.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Beat contents
//   req_     in         tuser operation; tdata pixel_index, red, green, blue
//   rsp_     out        tuser event_kind; tlast frame_end;
//                       tdata upper_rgb, lower_rgb, row_address
//   csr_     in         data threshold
//
// A pixel write is retired in a single back-end step; a shift or latch tick
// passes the execute step (a display store read for a shift), then the result
// step that loads the output register. A frame's first tick first copies all
// 2048 write store entries to the display store and then passes a drain step.
// After reset a clearing pass zeroes all 2048 write store entries, during
// which req_tready stays low. A stalled rsp_ holds the back end in its result
// step while the front end keeps filling the two-entry command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module led_matrix_scan_driver_core
   import lmsd_pkg::*;
#(
   parameter int PANEL_WIDTH = 64,
   parameter int PANEL_ROWS  = 1
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [10:0] pixel_index, [18:11] red, [26:19] green, [34:27] blue
   input  wire logic [39:0] req_tdata,
   // [0] operation
   input  wire logic        req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [2:0] upper_rgb, [5:3] lower_rgb, [9:6] row_address
   output logic [15:0]      rsp_tdata,
   // [0] event_kind
   output logic             rsp_tuser,
   output logic             rsp_tlast,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_data
);

   `include "led_matrix_scan_driver_core_assert.svh"

   logic [7:0]      threshold_ff, threshold_in;
   back_status_type status;
   logic            q_ready;
   logic            push;
   cmd_type         push_data;
   logic            q_pop;
   logic            q_valid;
   cmd_type         q_data;

   assign csr_ready    = 1'b1;
   assign threshold_in = (csr_valid && csr_ready) ? csr_data : threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
      end else begin
         threshold_ff <= threshold_in;
      end
   end

   lmsd_front #(
      .PANEL_WIDTH (PANEL_WIDTH),
      .PANEL_ROWS  (PANEL_ROWS)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .status     (status),
      .q_ready    (q_ready),
      .push       (push),
      .push_data  (push_data)
   );

   lmsd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .push_ready (q_ready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_data   (q_data)
   );

   lmsd_back #(
      .PANEL_WIDTH (PANEL_WIDTH),
      .PANEL_ROWS  (PANEL_ROWS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .threshold  (threshold_ff),
      .q_valid    (q_valid),
      .q_data     (q_data),
      .q_pop      (q_pop),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   `LMSD_ASSERT_CORE(a_no_accept_while_clearing, status.clearing |-> !req_tready, "beat accepted during store clearing")
   `LMSD_ASSERT_CORE(a_pop_needs_entry, q_pop |-> q_valid, "back end popped an empty queue")
   `LMSD_ASSERT_CORE(a_frame_end_on_latch, (rsp_tvalid && rsp_tlast) |-> (rsp_tuser == EV_LATCH), "frame end on a shift beat")

endmodule

`default_nettype wire

/* tb/led_matrix_scan_driver_core_tb.sv */
// ----------------------------------------------------------------------------
// LED matrix scan driver core testbench
// Streams pixel writes and scan ticks into the core under random sender gaps
// and receiver stalls, predicts every shift and latch beat from a model of the
// write store, the per-frame display copy and the scan counters, and compares
// each result beat field by field. The threshold is changed between phases.
// ----------------------------------------------------------------------------
module led_matrix_scan_driver_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lmsd_pkg::*;

   localparam int PANEL_WIDTH   = 64;
   localparam int PANEL_ROWS    = 1;
   localparam int PIXEL_COUNT   = PANEL_WIDTH * PANEL_HEIGHT * PANEL_ROWS;
   localparam int IDLE_LIMIT    = 20000;
   localparam int SETTLE_CYCLES = 12;
   localparam int PHASE_ITEMS   = 255;

   typedef struct packed {
      logic       kind;
      logic [2:0] upper;
      logic [2:0] lower;
      logic [3:0] row;
      logic       frame_end;
   } scan_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data = '0;

   // Model of the block.
   logic [23:0] staged_pixels [STORE_DEPTH];
   logic [23:0] shown_pixels [STORE_DEPTH];
   logic [3:0]  row_q;
   logic [2:0]  panel_q;
   logic [6:0]  col_q;
   logic        frame_live;
   logic [7:0]  thresh_q;

   scan_beat_type expected_beats [$];
   scan_beat_type got_beat;
   scan_beat_type want_beat;

   int fail_count = 0;
   int report_count = 0;
   int idle_cycles = 0;
   int burst_left = 0;
   int ready_left = 0;

   led_matrix_scan_driver_core #(
      .PANEL_WIDTH (PANEL_WIDTH),
      .PANEL_ROWS  (PANEL_ROWS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [2:0] lit_bits(input logic [23:0] pixel);
      lit_bits[0] = pixel[23:16] > thresh_q;
      lit_bits[1] = pixel[15:8] > thresh_q;
      lit_bits[2] = pixel[7:0] > thresh_q;
   endfunction

   function automatic logic [23:0] shown_at(input int addr);
      if (addr >= STORE_DEPTH) begin
         return '0;
      end
      return shown_pixels[addr];
   endfunction

   // Applies one accepted item to the model and, for a tick, queues the beat it causes.
   function automatic void predict_scan_beat(input logic op, input logic [10:0] idx,
                                             input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b);
      scan_beat_type beat;
      int y;
      int upper_addr;
      int lower_addr;
      beat = '0;
      if (op == OP_WRITE) begin
         if (int'(idx) < PIXEL_COUNT) begin
            staged_pixels[idx] = {r, g, b};
         end
         return;
      end
      // The first tick of a frame takes its snapshot of the write store.
      if (!frame_live) begin
         shown_pixels = staged_pixels;
         frame_live = 1'b1;
      end
      beat.row = row_q;
      if (int'(panel_q) >= PANEL_ROWS) begin
         beat.kind = EV_LATCH;
         beat.frame_end = (int'(row_q) == HALF_ROWS - 1);
         panel_q = '0;
         col_q = '0;
         row_q = row_q + 4'd1;
         if (row_q == 4'd0) begin
            frame_live = 1'b0;
         end
      end else begin
         y = int'(row_q) + PANEL_HEIGHT * int'(panel_q);
         upper_addr = y * PANEL_WIDTH + int'(col_q);
         lower_addr = (y + HALF_ROWS) * PANEL_WIDTH + int'(col_q);
         beat.kind = EV_SHIFT;
         beat.upper = lit_bits(shown_at(upper_addr));
         beat.lower = lit_bits(shown_at(lower_addr));
         if (int'(col_q) + 1 >= PANEL_WIDTH) begin
            col_q = '0;
            panel_q = panel_q + 3'd1;
         end else begin
            col_q = col_q + 7'd1;
         end
      end
      expected_beats.push_back(beat);
   endfunction

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic send_item(input logic op, input logic [10:0] idx, input logic [7:0] r,
                            input logic [7:0] g, input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_tuser = op;
      req_tdata = {5'd0, b, g, r, idx};
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_scan_beat(op, idx, r, g, b);
      @(negedge clock);
      burst_left--;
   endtask

   task automatic send_tick();
      send_item(OP_TICK, 11'($urandom_range(0, 2047)), 8'($urandom), 8'($urandom),
                8'($urandom));
   endtask

   task automatic drain_results();
      req_tvalid = 1'b0;
      burst_left = 0;
      while (expected_beats.size() != 0) @(negedge clock);
      // Pixel writes leave no beat behind, so give the back end time to retire them.
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_threshold(input logic [7:0] value);
      drain_results();
      csr_data = value;
      csr_valid = 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      thresh_q = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic [7:0] pick_level();
      case ($urandom_range(0, 7))
         0: return 8'd0;
         1: return 8'd255;
         2: return thresh_q;
         3: return thresh_q + 8'd1;
         4: return thresh_q - 8'd1;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic test_directed_pixels();
      send_item(OP_WRITE, 11'd0, 8'd255, 8'd255, 8'd255);
      send_item(OP_WRITE, 11'd1, 8'd129, 8'd128, 8'd0);
      send_item(OP_WRITE, 11'd2, 8'd128, 8'd129, 8'd200);
      send_item(OP_WRITE, 11'd1024, 8'd0, 8'd255, 8'd129);
      send_item(OP_WRITE, 11'd1025, 8'd255, 8'd0, 8'd0);
      send_item(OP_WRITE, 11'd1023, 8'd1, 8'd2, 8'd3);
      send_item(OP_WRITE, 11'd2047, 8'd255, 8'd255, 8'd255);
      send_item(OP_WRITE, 11'd64, 8'd200, 8'd200, 8'd200);
      repeat (4) send_tick();
      // Written mid-frame, so row 0 keeps its old colors until the next frame.
      send_item(OP_WRITE, 11'd0, 8'd0, 8'd0, 8'd0);
      send_item(OP_WRITE, 11'd3, 8'd255, 8'd255, 8'd255);
      repeat (2) send_tick();
   endtask

   task automatic test_threshold_extremes();
      write_threshold(8'd0);
      repeat (3) send_tick();
      write_threshold(8'd255);
      repeat (3) send_tick();
      write_threshold(THRESHOLD_RESET);
   endtask

   task automatic test_random_scan();
      logic [7:0] levels [6];
      levels = '{8'd0, 8'd255, 8'($urandom), 8'd1, 8'd254, 8'($urandom)};
      foreach (levels[p]) begin
         write_threshold(levels[p]);
         repeat (PHASE_ITEMS) begin
            if ($urandom_range(0, 3) != 0) begin
               send_tick();
            end else begin
               send_item(OP_WRITE, 11'($urandom_range(0, 2047)), pick_level(), pick_level(),
                         pick_level());
            end
         end
      end
   endtask

   // Receiver: random ready and stall runs, with occasional long ready runs.
   always @(negedge clock) begin
      if (ready_left == 0) begin
         case ($urandom_range(0, 5))
            0: begin
               rsp_tready <= 1'b1;
               ready_left = $urandom_range(100, 300);
            end
            1, 2: begin
               rsp_tready <= 1'b0;
               ready_left = $urandom_range(1, 12);
            end
            default: begin
               rsp_tready <= 1'b1;
               ready_left = $urandom_range(1, 40);
            end
         endcase
      end
      ready_left--;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_beat.kind = rsp_tuser;
         got_beat.upper = rsp_tdata[2:0];
         got_beat.lower = rsp_tdata[5:3];
         got_beat.row = rsp_tdata[9:6];
         got_beat.frame_end = rsp_tlast;
         if (expected_beats.size() == 0) begin
            fail_count++;
            if (report_count < 10) begin
               report_count++;
               $display("[%0t] unexpected beat: kind=%0b up=%0d lo=%0d row=%0d end=%0b",
                        $realtime, got_beat.kind, got_beat.upper, got_beat.lower,
                        got_beat.row, got_beat.frame_end);
            end
         end else begin
            want_beat = expected_beats.pop_front();
            if (got_beat.kind !== want_beat.kind || got_beat.upper !== want_beat.upper ||
                got_beat.lower !== want_beat.lower || got_beat.row !== want_beat.row ||
                got_beat.frame_end !== want_beat.frame_end) begin
               fail_count++;
               if (report_count < 10) begin
                  report_count++;
                  $display("[%0t] beat mismatch: expected kind=%0b up=%0d lo=%0d row=%0d end=%0b",
                           $realtime, want_beat.kind, want_beat.upper, want_beat.lower,
                           want_beat.row, want_beat.frame_end);
                  $display("                       actual kind=%0b up=%0d lo=%0d row=%0d end=%0b",
                           got_beat.kind, got_beat.upper, got_beat.lower, got_beat.row,
                           got_beat.frame_end);
               end
            end
         end
      end
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("** led_matrix_scan_driver_core: FAILED **");
         $finish;
      end
   end

   initial begin
      foreach (staged_pixels[i]) begin
         staged_pixels[i] = '0;
         shown_pixels[i] = '0;
      end
      row_q = '0;
      panel_q = '0;
      col_q = '0;
      frame_live = 1'b0;
      thresh_q = THRESHOLD_RESET;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_pixels();
      test_threshold_extremes();
      test_random_scan();
      drain_results();

      if (fail_count == 0) begin
         $display("** led_matrix_scan_driver_core: PASSED **");
      end else begin
         $display("** led_matrix_scan_driver_core: FAILED **");
      end
      $finish;
   end

endmodule
